// ===== hw/rtl/deadline_ordered_timer_queue_core_macros.svh =====
// ----------------------------------------------------------------------------
// deadline ordered timer queue: assertion macros
// concurrent assertion wrappers, removed when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef DEADLINE_ORDERED_TIMER_QUEUE_CORE_MACROS_SVH
`define DEADLINE_ORDERED_TIMER_QUEUE_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// checked property, off while in reset
`define DOT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// implication whose consequent is checked in the next cycle, off while in reset
`define DOT_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define DOT_ASSERT(lbl, clk, rst_n, prop, msg)
`define DOT_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

// ===== hw/rtl/dot_pkg.sv =====
// ----------------------------------------------------------------------------
// dot_pkg
// shared types and constants of the deadline ordered timer queue
// ----------------------------------------------------------------------------
package dot_pkg;

	localparam int NUM_SLOTS_DEF = 16;
	localparam int SLOT_BITS     = 4;
	localparam int DELAY_W       = 32;
	localparam int NOW_W         = 48;
	localparam int WAIT_W        = 32;
	localparam int PROD_W        = 42;
	localparam int DL_W          = 50;

	localparam int REM_W      = 10;
	localparam int DIV_W      = 42;
	localparam int PRE_SH     = 3;
	localparam int Z_W        = DIV_W - PRE_SH;
	localparam int LO_W       = 20;
	localparam int HI_W       = Z_W - LO_W;
	localparam int PART_W     = 26;
	localparam int BASE_W     = 33;
	localparam int RECIP_W    = 27;
	localparam int RECIP_SH   = 33;
	localparam int RPROD_W    = PART_W + RECIP_W;
	localparam int DIV_CYCLES = 3;
	localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

	localparam logic [REM_W-1:0] MS_US    = 10'd1000;
	localparam logic [REM_W-1:0] ROUND_UP = 10'd999;

	// 2^20 = 125 * 8388 + 76; ceil(2^33 / 125)
	localparam logic [PART_W-1:0]  HI_REM    = 26'd76;
	localparam logic [BASE_W-1:0]  HI_QUO    = 33'd8388;
	localparam logic [RECIP_W-1:0] RECIP_125 = 27'd68719477;

	localparam logic [WAIT_W-1:0] WAIT_EMPTY = 32'hFFFF_FFFF;
	localparam logic [WAIT_W-1:0] WAIT_SAT   = 32'hFFFF_FFFE;
	localparam logic signed [DL_W-1:0] SAT_LIMIT = 50'sd4294967294000;

	typedef enum logic [1:0] {
		ACT_SCHEDULE   = 2'd0,
		ACT_RESCHEDULE = 2'd1,
		ACT_CANCEL     = 2'd2,
		ACT_POLL       = 2'd3
	} action_t;

	typedef struct packed {
		action_t                    action;
		logic [SLOT_BITS-1:0]       slot_id;
		logic signed [DELAY_W-1:0]  dly_ms;
		logic [NOW_W-1:0]           now_us;
	} req_item_t;

	typedef struct packed {
		logic                  fired;
		logic [SLOT_BITS-1:0]  fired_slot;
		logic [WAIT_W-1:0]     next_wait_ms;
		logic                  last_result;
	} rsp_item_t;

	typedef struct packed {
		logic                    valid;
		logic [SLOT_BITS-1:0]    slot;
		logic signed [DL_W-1:0]  dl;
	} entry_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_REMOVE,
		CELL_INSERT
	} cell_op_t;

	typedef struct packed {
		cell_op_t                op;
		logic [SLOT_BITS-1:0]    slot;
		logic signed [DL_W-1:0]  dl;
	} cell_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_REMOVE,
		ST_INSERT,
		ST_POLL,
		ST_WSUB,
		ST_WCHK,
		ST_DIV,
		ST_EMIT
	} dot_state_t;

endpackage

// ===== hw/rtl/dot_cell.sv =====
// ----------------------------------------------------------------------------
// dot_cell
// one place of the sorted timer list; shifts with its neighbours
// ----------------------------------------------------------------------------
module dot_cell import dot_pkg::*; #(
	parameter int IW  = 4,
	parameter int IDX = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  cell_ctl_t      ctl,
	input  logic [IW-1:0]  rm_idx,
	input  entry_t         left,
	input  logic           left_shift,
	input  entry_t         right,
	output entry_t         entry,
	output logic           shift,
	output logic           match
);

	logic                    valid_q;
	logic [SLOT_BITS-1:0]    slot_q;
	logic signed [DL_W-1:0]  dl_q;
	entry_t                  cur;
	entry_t                  nxt;

	assign cur   = '{valid: valid_q, slot: slot_q, dl: dl_q};
	assign entry = cur;

	// new deadline goes at or before this place; equal deadlines stay ahead
	assign shift = !valid_q || (dl_q > ctl.dl);
	assign match = valid_q && (slot_q == ctl.slot);

	always_comb begin
		nxt = cur;
		case (ctl.op)
			CELL_REMOVE: begin
				if (IW'(IDX) >= rm_idx) begin
					nxt = right;
				end
			end
			CELL_INSERT: begin
				if (shift) begin
					nxt = left_shift ? left : '{valid: 1'b1, slot: ctl.slot, dl: ctl.dl};
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		slot_q <= nxt.slot;
		dl_q   <= nxt.dl;
	end

endmodule

// ===== hw/rtl/dot_wait_div.sv =====
// ----------------------------------------------------------------------------
// dot_wait_div
// divide by 1000 through a reciprocal multiply over three pipeline stages
// ----------------------------------------------------------------------------
module dot_wait_div import dot_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_W-1:0]   dividend,
	output logic               busy,
	output logic [WAIT_W-1:0]  quotient
);

	logic                  busy_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [Z_W-1:0]        dvd_q;
	logic [HI_W-1:0]       hi;
	logic [LO_W-1:0]       lo;
	logic [PART_W-1:0]     part_s1;
	logic [BASE_W-1:0]     base_s1;
	logic [RPROD_W-1:0]    rprod_s2;
	logic [BASE_W-1:0]     base_s2;
	logic [WAIT_W-1:0]     quo_q;

	// dividend / 8 = hi * 2^20 + lo, then divide by 125
	assign hi = dvd_q[Z_W-1 -: HI_W];
	assign lo = dvd_q[LO_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_CYCLES);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// quotient fits in 32 bits
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend[DIV_W-1:PRE_SH];
		end
		part_s1  <= PART_W'(hi) * HI_REM + PART_W'(lo);
		base_s1  <= BASE_W'(hi) * HI_QUO;
		rprod_s2 <= RPROD_W'(part_s1) * RPROD_W'(RECIP_125);
		base_s2  <= base_s1;
		quo_q    <= WAIT_W'(base_s2 + BASE_W'(rprod_s2[RPROD_W-1:RECIP_SH]));
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// ===== hw/rtl/deadline_ordered_timer_queue_core.sv =====
// ----------------------------------------------------------------------------
// deadline_ordered_timer_queue_core
// timer slots kept in a row of cells sorted by deadline, fifo among equals
// ----------------------------------------------------------------------------
// req carries one command (schedule, reschedule, cancel or poll) on a
// valid/ready channel; rsp returns result transactions on valid/ready.
// one command is worked on at a time; req_ready is high only while idle.
// schedule, reschedule, cancel: after acceptance the block passes prep,
// a removal and/or an insertion as needed, then works out the wait and
// loads the result; a finite wait that has to be divided down adds the divide.
// poll: due slots are popped from the head of the row one by one, each
// popped slot returned in a result transaction, the last one in the final
// result; then the wait is worked out, with the same divide for a finite wait.
// req_ready returns once the final result is loaded.
// the wait is ceil(us / 1000), worked out by a reciprocal multiply over 3
// pipeline stages; every cell shifts in step, so each list edit is one state.
// results go through one output register, so a new command is taken while
// the last result still waits; a stalled rsp holds the block before its next
// result transaction. reset empties the row at once; no clearing pass.
// ----------------------------------------------------------------------------
`include "deadline_ordered_timer_queue_core_macros.svh"

module deadline_ordered_timer_queue_core import dot_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  req_item_t  req,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_item_t  rsp
);

	localparam int IW = $clog2(NUM_SLOTS);

	dot_state_t  state_q, state_d;

	req_item_t                 cmd_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [DL_W-1:0]    dl_q;
	logic signed [DL_W-1:0]    diff_q;
	logic signed [DL_W-1:0]    now_ext;
	logic [IW-1:0]             rm_idx_q;
	logic [IW-1:0]             match_idx;
	logic                      need_ins_q;
	logic                      empty_q;
	logic                      zero_q;
	logic [WAIT_W-1:0]         wait_q;
	logic                      held_q;
	logic [SLOT_BITS-1:0]      held_slot_q;
	logic                      rsp_valid_q;
	rsp_item_t                 rsp_q;

	entry_t          cell_ent [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]  cell_shift;
	logic [NUM_SLOTS-1:0]  cell_match;
	logic [NUM_SLOTS-1:0]  cell_vld;
	logic [NUM_SLOTS-2:0]  sorted_ok;
	cell_ctl_t       ctl;
	cell_op_t        cell_op;
	logic [IW-1:0]   rm_sel;

	logic       in_range;
	logic       found;
	logic       need_rem;
	logic       need_ins;
	logic       head_due;
	logic       sat;
	logic       wait_fixed;
	logic       rsp_free;
	logic       pop;
	logic       emit;
	rsp_item_t  emit_item;
	logic       div_start;
	logic       div_busy;
	logic [WAIT_W-1:0] div_quo;

	assign now_ext  = DL_W'(cmd_q.now_us);
	assign rsp_free = !rsp_valid_q || rsp_ready;
	assign in_range = 32'(cmd_q.slot_id) < 32'(NUM_SLOTS);
	assign found    = |cell_match;
	assign need_rem = found && (cmd_q.action == ACT_RESCHEDULE || cmd_q.action == ACT_CANCEL);
	assign need_ins = in_range && (cmd_q.action == ACT_RESCHEDULE ||
		(cmd_q.action == ACT_SCHEDULE && !found));
	assign head_due   = cell_ent[0].valid && (cell_ent[0].dl <= now_ext);
	assign sat        = diff_q > SAT_LIMIT;
	assign wait_fixed = empty_q || zero_q || sat;

	assign ctl = '{op: cell_op, slot: cmd_q.slot_id, dl: dl_q};

	// cell row
	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		entry_t  lft;
		entry_t  rgt;
		logic    lft_shift;

		if (i == 0) begin : g_head
			assign lft       = '0;
			assign lft_shift = 1'b0;
		end else begin : g_body
			assign lft       = cell_ent[i-1];
			assign lft_shift = cell_shift[i-1];
		end

		if (i == NUM_SLOTS - 1) begin : g_tail
			assign rgt = '0;
		end else begin : g_link
			assign rgt = cell_ent[i+1];
		end

		dot_cell #(
			.IW  (IW),
			.IDX (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.rm_idx     (rm_sel),
			.left       (lft),
			.left_shift (lft_shift),
			.right      (rgt),
			.entry      (cell_ent[i]),
			.shift      (cell_shift[i]),
			.match      (cell_match[i])
		);

		assign cell_vld[i] = cell_ent[i].valid;
	end

	always_comb begin
		match_idx = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (cell_match[i]) begin
				match_idx = match_idx | IW'(i);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_SLOTS - 1; i++) begin
			sorted_ok[i] = !cell_ent[i+1].valid || (cell_ent[i].dl <= cell_ent[i+1].dl);
		end
	end

	dot_wait_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (DIV_W'(diff_q) + DIV_W'(ROUND_UP)),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				if (cmd_q.action == ACT_POLL) begin
					state_d = ST_POLL;
				end else if (need_rem) begin
					state_d = ST_REMOVE;
				end else if (need_ins) begin
					state_d = ST_INSERT;
				end else begin
					state_d = ST_WSUB;
				end
			end
			ST_REMOVE: begin
				state_d = need_ins_q ? ST_INSERT : ST_WSUB;
			end
			ST_INSERT: begin
				state_d = ST_WSUB;
			end
			ST_POLL: begin
				if (!head_due) begin
					state_d = ST_WSUB;
				end
			end
			ST_WSUB: begin
				state_d = ST_WCHK;
			end
			ST_WCHK: begin
				state_d = wait_fixed ? ST_EMIT : ST_DIV;
			end
			ST_DIV: begin
				if (!div_busy) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		req_ready = 1'b0;
		cell_op   = CELL_HOLD;
		rm_sel    = rm_idx_q;
		pop       = 1'b0;
		emit      = 1'b0;
		emit_item = '0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
			end
			ST_REMOVE: begin
				cell_op = CELL_REMOVE;
			end
			ST_INSERT: begin
				cell_op = CELL_INSERT;
			end
			ST_POLL: begin
				if (head_due && (!held_q || rsp_free)) begin
					pop       = 1'b1;
					cell_op   = CELL_REMOVE;
					rm_sel    = '0;
					emit      = held_q;
					emit_item = '{fired: 1'b1, fired_slot: held_slot_q,
						next_wait_ms: '0, last_result: 1'b0};
				end
			end
			ST_WCHK: begin
				div_start = !wait_fixed;
			end
			ST_EMIT: begin
				emit      = rsp_free;
				emit_item = '{fired: held_q, fired_slot: held_q ? held_slot_q : '0,
					next_wait_ms: wait_q, last_result: 1'b1};
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			held_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (req_valid && req_ready) begin
				held_q <= 1'b0;
			end else if (pop) begin
				held_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			cmd_q  <= req;
			prod_q <= PROD_W'(req.dly_ms) * PROD_W'(MS_US);
		end
		if (state_q == ST_PREP) begin
			dl_q       <= DL_W'(prod_q) + now_ext;
			rm_idx_q   <= match_idx;
			need_ins_q <= need_ins;
		end
		if (pop) begin
			held_slot_q <= cell_ent[0].slot;
		end
		if (state_q == ST_WSUB) begin
			empty_q <= !cell_ent[0].valid;
			zero_q  <= cell_ent[0].dl <= now_ext;
			diff_q  <= cell_ent[0].dl - now_ext;
		end
		if (state_q == ST_WCHK) begin
			wait_q <= empty_q ? WAIT_EMPTY : (zero_q ? '0 : WAIT_SAT);
		end else if (state_q == ST_DIV && !div_busy) begin
			wait_q <= div_quo;
		end
		if (emit) begin
			rsp_q <= emit_item;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`DOT_ASSERT(a_row_contiguous, clk, arst_n, (cell_vld & (cell_vld + 1'b1)) == '0, "gap in timer row")
	`DOT_ASSERT(a_row_sorted, clk, arst_n, &sorted_ok, "timer row out of deadline order")
	`DOT_ASSERT(a_slot_unique, clk, arst_n, $onehot0(cell_match), "slot held by more than one cell")
	`DOT_ASSERT(a_insert_room, clk, arst_n, state_q == ST_INSERT |-> !cell_vld[NUM_SLOTS-1], "insert drops an entry")
	`DOT_ASSERT_NEXT(a_div_result, clk, arst_n, state_q == ST_WCHK && !wait_fixed, div_busy, "divider not started")

endmodule
